// ===== sv/tkpd_pkg.sv =====
// ============================================================================
// tkpd_pkg
// Shared types and constants for the touch key presence detector.
// ============================================================================
package tkpd_pkg;

   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 40;
   localparam int RSP_TUSER_W   = 1;
   localparam int LEVEL_W       = 16;

   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 12;

   localparam int MARGIN_W      = 12;
   localparam int PRESS_CNT_W   = 11;
   localparam int IDLE_CNT_W    = 10;

   localparam logic [MARGIN_W-1:0]    PRESS_MARGIN_RST      = 12'd40;
   localparam logic [MARGIN_W-1:0]    RELEASE_MARGIN_RST    = 12'd30;
   localparam logic [PRESS_CNT_W-1:0] PRESS_HOLD_COUNT_RST  = 11'd100;
   localparam logic [PRESS_CNT_W-1:0] RECAL_PRESS_LIMIT_RST = 11'd1500;
   localparam logic [IDLE_CNT_W-1:0]  RECAL_IDLE_LIMIT_RST  = 10'd500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESS_MARGIN      = 3'd0,
      CSR_RELEASE_MARGIN    = 3'd1,
      CSR_PRESS_HOLD_COUNT  = 3'd2,
      CSR_RECAL_PRESS_LIMIT = 3'd3,
      CSR_RECAL_IDLE_LIMIT  = 3'd4
   } csr_index_type;

endpackage

// ===== sv/touch_key_presence_detector_core.sv =====
// ============================================================================
// touch_key_presence_detector_core
// Capacitive touch key detector: calibrated baseline, moving-average window,
// press/idle counters with baseline recalibration and a toggled light.
//
//   channel   dir   ports                           beat
//   req       in    req_tvalid/tready/tdata         one oscillator sample
//   rsp       out   rsp_tvalid/tready/tdata/tuser   one status result
//   csr       in    csr_wr_en/csr_index/csr_wdata   one register write
//
// Two register stages: the input stage updates calibration sum and window,
// the result stage divides by constant reciprocal, compares and counts.
// One beat per cycle sustained while rsp is ready; a beat passes the input stage register, then the result register.
// Synchronous active-high reset clears the window, counters and valid flags and loads the CSR reset values.
// A stalled rsp holds the result and fills the input stage, then req stalls.
// ============================================================================
module touch_key_presence_detector_core #(
   parameter int WINDOW_LEN   = 20,
   parameter int CALIB_LEN    = 20,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tkpd_pkg::REQ_TDATA_W-1:0]    req_tdata,   // sample[15:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // light[0], average[16:1], baseline[32:17], pressed[33], zero[39:34]
   output logic [tkpd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [tkpd_pkg::RSP_TUSER_W-1:0]    rsp_tuser,   // calibrating[0]
   input  logic                                csr_wr_en,
   input  logic [tkpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tkpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tkpd_pkg::*;

   localparam int SW      = SAMPLE_WIDTH;
   localparam int WPOS_W  = $clog2(WINDOW_LEN);
   localparam int WSUM_W  = $clog2(WINDOW_LEN * (2**SW - 1) + 1);
   localparam int CCNT_W  = $clog2(CALIB_LEN + 1);
   localparam int CSUM_W  = $clog2(CALIB_LEN * (2**SW - 1) + 1);

   // floor(x / D) = (x * ceil(2^S / D)) >> S, S = width(x) + clog2(D)
   localparam int    WDIV_SH  = WSUM_W + $clog2(WINDOW_LEN);
   localparam int    WDIV_MW  = WSUM_W + 1;
   localparam int    WPROD_W  = WSUM_W + WDIV_MW;
   localparam longint WDIV_ML = ((longint'(1) << WDIV_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam logic [WDIV_MW-1:0] WDIV_MUL = WDIV_MW'(WDIV_ML);

   localparam int    CDIV_SH  = CSUM_W + $clog2(CALIB_LEN);
   localparam int    CDIV_MW  = CSUM_W + 1;
   localparam int    CPROD_W  = CSUM_W + CDIV_MW;
   localparam longint CDIV_ML = ((longint'(1) << CDIV_SH) + CALIB_LEN - 1) / CALIB_LEN;
   localparam logic [CDIV_MW-1:0] CDIV_MUL = CDIV_MW'(CDIV_ML);

   localparam logic [CCNT_W-1:0] CALIB_END  = CCNT_W'(CALIB_LEN);
   localparam logic [CCNT_W-1:0] CALIB_LAST = CCNT_W'(CALIB_LEN - 1);
   localparam logic [WPOS_W-1:0] WPOS_LAST  = WPOS_W'(WINDOW_LEN - 1);

   // configuration
   logic [MARGIN_W-1:0]    press_margin_ff;
   logic [MARGIN_W-1:0]    release_margin_ff;
   logic [PRESS_CNT_W-1:0] press_hold_count_ff;
   logic [PRESS_CNT_W-1:0] recal_press_limit_ff;
   logic [IDLE_CNT_W-1:0]  recal_idle_limit_ff;

   // input stage state
   logic [CCNT_W-1:0]  calib_count_ff;
   logic [CSUM_W-1:0]  calib_sum_ff;
   logic [SW-1:0]      window_ff [WINDOW_LEN];
   logic [WPOS_W-1:0]  window_pos_ff;
   logic [WSUM_W-1:0]  window_sum_ff;

   // input stage register
   logic               s1_valid_ff;
   logic               s1_calib_ff;
   logic               s1_load_ff;
   logic [CSUM_W-1:0]  s1_csum_ff;
   logic [WSUM_W-1:0]  s1_wsum_ff;

   // detector state
   logic [LEVEL_W-1:0]     reference_level_ff;
   logic [PRESS_CNT_W-1:0] press_count_ff;
   logic [IDLE_CNT_W-1:0]  idle_count_ff;
   logic                   light_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_light_ff;
   logic [LEVEL_W-1:0] rsp_average_ff;
   logic [LEVEL_W-1:0] rsp_baseline_ff;
   logic               rsp_calib_ff;
   logic               rsp_pressed_ff;

   logic               s1_move;
   logic               req_accept;
   logic               calib_phase;
   logic [SW-1:0]      sample;
   logic [SW-1:0]      window_old;
   logic [CSUM_W-1:0]  csum_upd;
   logic [WSUM_W-1:0]  wsum_upd;

   logic [WPROD_W-1:0] wdiv_prod;
   logic [WPROD_W-1:0] wdiv_shift;
   logic [CPROD_W-1:0] cdiv_prod;
   logic [CPROD_W-1:0] cdiv_shift;
   logic [LEVEL_W-1:0] average;
   logic [LEVEL_W-1:0] calib_mean;

   logic                   is_press;
   logic                   is_release;
   logic [PRESS_CNT_W:0]   press_inc;
   logic [IDLE_CNT_W:0]    idle_inc;
   logic [LEVEL_W-1:0]     reference_level_in;
   logic [PRESS_CNT_W-1:0] press_count_in;
   logic [IDLE_CNT_W-1:0]  idle_count_in;
   logic                   light_in;
   logic                   pressed;

   assign s1_move     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_move;
   assign req_accept  = req_tvalid && req_tready;

   assign calib_phase = calib_count_ff < CALIB_END;
   assign sample      = req_tdata[SW-1:0];
   assign window_old  = window_ff[window_pos_ff];
   assign csum_upd    = calib_sum_ff + CSUM_W'(sample);
   assign wsum_upd    = window_sum_ff - WSUM_W'(window_old) + WSUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         press_margin_ff      <= PRESS_MARGIN_RST;
         release_margin_ff    <= RELEASE_MARGIN_RST;
         press_hold_count_ff  <= PRESS_HOLD_COUNT_RST;
         recal_press_limit_ff <= RECAL_PRESS_LIMIT_RST;
         recal_idle_limit_ff  <= RECAL_IDLE_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PRESS_MARGIN:      press_margin_ff      <= csr_wdata[MARGIN_W-1:0];
            CSR_RELEASE_MARGIN:    release_margin_ff    <= csr_wdata[MARGIN_W-1:0];
            CSR_PRESS_HOLD_COUNT:  press_hold_count_ff  <= csr_wdata[PRESS_CNT_W-1:0];
            CSR_RECAL_PRESS_LIMIT: recal_press_limit_ff <= csr_wdata[PRESS_CNT_W-1:0];
            CSR_RECAL_IDLE_LIMIT:  recal_idle_limit_ff  <= csr_wdata[IDLE_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_count_ff <= '0;
         calib_sum_ff   <= '0;
         window_pos_ff  <= '0;
         window_sum_ff  <= '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
      end else if (req_accept) begin
         if (calib_phase) begin
            calib_count_ff <= calib_count_ff + 1'b1;
            calib_sum_ff   <= csum_upd;
         end else begin
            window_ff[window_pos_ff] <= sample;
            window_sum_ff            <= wsum_upd;
            window_pos_ff <= (window_pos_ff == WPOS_LAST) ? '0 : window_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_calib_ff <= calib_phase;
         s1_load_ff  <= calib_phase && (calib_count_ff == CALIB_LAST);
         s1_csum_ff  <= csum_upd;
         s1_wsum_ff  <= calib_phase ? window_sum_ff : wsum_upd;
      end
   end

   assign wdiv_prod  = WPROD_W'(s1_wsum_ff) * WPROD_W'(WDIV_MUL);
   assign wdiv_shift = wdiv_prod >> WDIV_SH;
   assign average    = LEVEL_W'(wdiv_shift[SW-1:0]);
   assign cdiv_prod  = CPROD_W'(s1_csum_ff) * CPROD_W'(CDIV_MUL);
   assign cdiv_shift = cdiv_prod >> CDIV_SH;
   assign calib_mean = LEVEL_W'(cdiv_shift[SW-1:0]);

   // compares in one extra bit, no wrap of baseline minus margin
   assign is_press   = ((LEVEL_W+1)'(average) + (LEVEL_W+1)'(press_margin_ff))
                       < (LEVEL_W+1)'(reference_level_ff);
   assign is_release = ((LEVEL_W+1)'(average) + (LEVEL_W+1)'(release_margin_ff))
                       > (LEVEL_W+1)'(reference_level_ff);
   assign press_inc  = (PRESS_CNT_W+1)'(press_count_ff) + 1'b1;
   assign idle_inc   = (IDLE_CNT_W+1)'(idle_count_ff) + 1'b1;

   always_comb begin
      reference_level_in = reference_level_ff;
      press_count_in     = press_count_ff;
      idle_count_in      = idle_count_ff;
      light_in           = light_ff;
      pressed            = 1'b0;
      if (s1_calib_ff) begin
         if (s1_load_ff) begin
            reference_level_in = calib_mean;
         end
      end else begin
         if (is_press) begin
            pressed = 1'b1;
            if (press_inc > (PRESS_CNT_W+1)'(recal_press_limit_ff)) begin
               press_count_in     = '0;
               reference_level_in = average;
            end else begin
               press_count_in = press_inc[PRESS_CNT_W-1:0];
            end
         end else if (is_release) begin
            press_count_in = '0;
            if (idle_inc > (IDLE_CNT_W+1)'(recal_idle_limit_ff)) begin
               idle_count_in      = '0;
               reference_level_in = average;
            end else begin
               idle_count_in = idle_inc[IDLE_CNT_W-1:0];
            end
         end
         if (press_count_in == press_hold_count_ff) begin
            light_in = !light_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_level_ff <= '0;
         press_count_ff     <= '0;
         idle_count_ff      <= '0;
         light_ff           <= 1'b0;
      end else if (s1_move) begin
         reference_level_ff <= reference_level_in;
         press_count_ff     <= press_count_in;
         idle_count_ff      <= idle_count_in;
         light_ff           <= light_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_light_ff    <= light_in;
         rsp_average_ff  <= average;
         rsp_baseline_ff <= reference_level_in;
         rsp_calib_ff    <= s1_calib_ff;
         rsp_pressed_ff  <= pressed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_pressed_ff, rsp_baseline_ff, rsp_average_ff, rsp_light_ff};
   assign rsp_tuser  = rsp_calib_ff;

   a_press_not_calib: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_calib_ff && rsp_pressed_ff))
      else $error("pressed flagged on a calibration beat");

   a_window_empty_in_calib: assert property (@(posedge clock) disable iff (reset)
      calib_phase |-> (window_sum_ff == '0))
      else $error("window sum nonzero during calibration");

   a_calib_count_range: assert property (@(posedge clock) disable iff (reset)
      calib_count_ff <= CALIB_END)
      else $error("calibration count past its end");

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |=> (s1_valid_ff && $stable(s1_wsum_ff)))
      else $error("input stage lost its beat while result stalled");

endmodule
